// File: src/dltq_pkg.sv
package dltq_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int ID_BITS_DEF = 8;
    localparam int MAX_POPS    = 16;

    localparam logic [2:0] REQ_REGISTER = 3'd0;
    localparam logic [2:0] REQ_REMOVE   = 3'd1;
    localparam logic [2:0] REQ_FIND     = 3'd2;
    localparam logic [2:0] REQ_QUERY    = 3'd3;
    localparam logic [2:0] REQ_TICK     = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EXISTS   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_REMOVE,
        S_INS_WALK,
        S_INSERT,
        S_ADVANCE,
        S_POP_CHECK,
        S_POP,
        S_OUT,
        S_OUT_WAIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the request
        logic search;      // search for the id (combinational result)
        logic drop_found;  // remove the found slot
        logic drop_head;   // remove slot 0 and record its id
        logic walk_clr;    // restart the list walk at slot 0
        logic ins_step;    // walk past one slot while looking for the insert position
        logic insert;      // place the new timer at the walk position
        logic adv_step;    // subtract elapsed time from the slot at the walk position
        logic clr_pops;    // clear the pop counter
        logic emit;        // load output register
        logic emit_pop;    // output carries a popped id
        logic next_pop;    // step the output pop pointer
        logic [1:0] status;
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic [2:0] req;
        logic       ow;
        logic       found;
        logic       full;
        logic       empty;
        logic       ins_stop;
        logic       adv_done;
        logic       head_exp;
        logic       pops_max;
        logic       pops_any;
        logic       out_last;
    } t_stat;

endpackage

// File: src/dltq_ctrl.sv
module dltq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  dltq_pkg::t_stat  i_stat,
    output dltq_pkg::t_cmd   o_cmd
);

    dltq_pkg::t_state r_state, n_state;
    logic [1:0]       r_status, n_status;
    logic             r_popmode, n_popmode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dltq_pkg::S_IDLE;
            r_status  <= dltq_pkg::ST_OK;
            r_popmode <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_popmode <= n_popmode;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_popmode   = r_popmode;
        o_cmd       = '0;
        o_cmd.status = r_status;
        o_cmd.emit_pop = r_popmode;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            dltq_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.clr_pops = 1'b1;
                    n_status       = dltq_pkg::ST_OK;
                    n_popmode      = 1'b0;
                    n_state        = dltq_pkg::S_DECODE;
                end
            end
            dltq_pkg::S_DECODE: begin
                o_cmd.search   = 1'b1;
                o_cmd.walk_clr = 1'b1;
                priority case (i_stat.req)
                    dltq_pkg::REQ_REGISTER: begin
                        if (i_stat.found && !i_stat.ow) begin
                            n_status = dltq_pkg::ST_EXISTS;
                            n_state  = dltq_pkg::S_OUT;
                        end else if (i_stat.found) begin
                            n_state = dltq_pkg::S_REMOVE;
                        end else if (i_stat.full) begin
                            n_status = dltq_pkg::ST_FULL;
                            n_state  = dltq_pkg::S_OUT;
                        end else begin
                            n_state = dltq_pkg::S_INS_WALK;
                        end
                    end
                    dltq_pkg::REQ_REMOVE: begin
                        if (i_stat.found) begin
                            n_state = dltq_pkg::S_REMOVE;
                        end else begin
                            n_status = dltq_pkg::ST_NOTFOUND;
                            n_state  = dltq_pkg::S_OUT;
                        end
                    end
                    dltq_pkg::REQ_FIND: begin
                        if (!i_stat.found) begin
                            n_status = dltq_pkg::ST_NOTFOUND;
                        end
                        n_state = dltq_pkg::S_OUT;
                    end
                    dltq_pkg::REQ_TICK: begin
                        n_state = dltq_pkg::S_ADVANCE;
                    end
                    default: begin
                        n_state = dltq_pkg::S_OUT;
                    end
                endcase
            end
            dltq_pkg::S_REMOVE: begin
                o_cmd.search     = 1'b1;
                o_cmd.drop_found = 1'b1;
                o_cmd.walk_clr   = 1'b1;
                if (i_stat.req == dltq_pkg::REQ_REGISTER) begin
                    n_state = dltq_pkg::S_INS_WALK;
                end else begin
                    n_state = dltq_pkg::S_OUT;
                end
            end
            dltq_pkg::S_INS_WALK: begin
                if (i_stat.ins_stop) begin
                    n_state = dltq_pkg::S_INSERT;
                end else begin
                    o_cmd.ins_step = 1'b1;
                end
            end
            dltq_pkg::S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = dltq_pkg::S_OUT;
            end
            dltq_pkg::S_ADVANCE: begin
                if (i_stat.adv_done) begin
                    n_state = dltq_pkg::S_POP_CHECK;
                end else begin
                    o_cmd.adv_step = 1'b1;
                end
            end
            dltq_pkg::S_POP_CHECK: begin
                if (!i_stat.empty && i_stat.head_exp && !i_stat.pops_max) begin
                    n_state = dltq_pkg::S_POP;
                end else begin
                    n_popmode = i_stat.pops_any;
                    n_state   = dltq_pkg::S_OUT;
                end
            end
            dltq_pkg::S_POP: begin
                o_cmd.drop_head = 1'b1;
                n_state         = dltq_pkg::S_POP_CHECK;
            end
            dltq_pkg::S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = dltq_pkg::S_OUT_WAIT;
            end
            dltq_pkg::S_OUT_WAIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (i_stat.out_last) begin
                        n_state = dltq_pkg::S_IDLE;
                    end else begin
                        o_cmd.next_pop = 1'b1;
                        n_state        = dltq_pkg::S_OUT;
                    end
                end
            end
            default: begin
                n_state = dltq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: src/dltq_datapath.sv
module dltq_datapath #(
    parameter int ENTRIES = dltq_pkg::ENTRIES_DEF,
    parameter int ID_BITS = dltq_pkg::ID_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dltq_pkg::t_cmd  i_cmd,
    input  logic [2:0]      i_req_type,
    input  logic [7:0]      i_timer_id,
    input  logic [31:0]     i_duration_us,
    input  logic            i_overwrite,
    input  logic [31:0]     i_elapsed_us,
    input  logic [15:0]     i_min_delay_us,
    output dltq_pkg::t_stat o_stat,
    output logic [1:0]      o_status,
    output logic            o_expired_valid,
    output logic [7:0]      o_expired_id,
    output logic [31:0]     o_next_delay,
    output logic            o_queue_empty,
    output logic            o_last
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int PW = $clog2(dltq_pkg::MAX_POPS + 1);
    localparam int QW = $clog2(dltq_pkg::MAX_POPS);

    logic [ID_BITS-1:0] r_id    [ENTRIES];
    logic [31:0]        r_delta [ENTRIES];
    logic [CW-1:0]      r_count;
    logic [ID_BITS-1:0] r_pop_id [dltq_pkg::MAX_POPS];
    logic [PW-1:0]      r_npop;
    logic [QW-1:0]      r_opos;

    logic [2:0]         r_req;
    logic [ID_BITS-1:0] r_key;
    logic [31:0]        r_dur;
    logic               r_ow;
    logic [31:0]        r_elapsed;

    // List walk: slot pointer and the time still to be accounted for.
    logic [CW-1:0]      r_wi;
    logic [31:0]        r_rem;

    // Slot-wise compare: match flags are independent per slot.
    logic [ENTRIES-1:0] match;
    logic [IW-1:0]      found_idx;
    logic               found;
    logic [ENTRIES-1:0] live;

    always_comb begin
        found_idx = '0;
        found     = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            live[i]  = (CW'(i) < r_count);
            match[i] = live[i] && (r_id[i] == r_key);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                found     = 1'b1;
                found_idx = IW'(i);
            end
        end
    end

    // The slot under the walk pointer; one compare and one subtract per cycle.
    logic [IW-1:0] wi_idx;
    logic          wi_live;
    logic [31:0]   wi_delta;
    assign wi_idx   = r_wi[IW-1:0];
    assign wi_live  = (r_wi < r_count);
    assign wi_delta = r_delta[wi_idx];

    logic [IW-1:0] drop_k;
    logic          do_drop;
    logic [32:0]   sum_next;
    assign do_drop = i_cmd.drop_found || i_cmd.drop_head;
    assign drop_k  = i_cmd.drop_head ? '0 : found_idx;

    always_comb begin
        if (drop_k == IW'(ENTRIES - 1)) sum_next = '0;
        else sum_next = {1'b0, r_delta[drop_k + IW'(1)]} + {1'b0, r_delta[drop_k]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req_type;
            r_key     <= ID_BITS'(i_timer_id);
            r_dur     <= i_duration_us;
            r_ow      <= i_overwrite;
            r_elapsed <= i_elapsed_us;
        end
        if (i_cmd.walk_clr) begin
            r_wi  <= '0;
            r_rem <= (r_req == dltq_pkg::REQ_TICK) ? r_elapsed : r_dur;
        end else if (i_cmd.ins_step) begin
            r_wi  <= r_wi + CW'(1);
            r_rem <= r_rem - wi_delta;
        end else if (i_cmd.adv_step) begin
            if (wi_delta >= r_rem) begin
                r_rem <= '0;
            end else begin
                r_wi  <= r_wi + CW'(1);
                r_rem <= r_rem - wi_delta;
            end
        end
        if (do_drop) begin
            for (int i = 0; i < ENTRIES - 1; i++) begin
                if (IW'(i) >= drop_k) begin
                    r_id[i] <= r_id[i+1];
                    if (IW'(i) == drop_k)
                        r_delta[i] <= sum_next[32] ? 32'hFFFF_FFFF : sum_next[31:0];
                    else
                        r_delta[i] <= r_delta[i+1];
                end
            end
        end else if (i_cmd.insert) begin
            // The new timer lands at the walk position; the slot it displaces
            // moves up one place and keeps only the time beyond the new one.
            if (r_wi == '0) begin
                r_id[0]    <= r_key;
                r_delta[0] <= r_rem;
            end
            for (int i = 1; i < ENTRIES; i++) begin
                if (CW'(i) == r_wi) begin
                    r_id[i]    <= r_key;
                    r_delta[i] <= r_rem;
                end else if (CW'(i) > r_wi) begin
                    r_id[i]    <= r_id[i-1];
                    r_delta[i] <= (CW'(i - 1) == r_wi) ? r_delta[i-1] - r_rem
                                                       : r_delta[i-1];
                end
            end
        end else if (i_cmd.adv_step) begin
            r_delta[wi_idx] <= (wi_delta >= r_rem) ? wi_delta - r_rem : 32'd0;
        end
        if (i_cmd.drop_head) r_pop_id[r_npop[QW-1:0]] <= r_id[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_npop  <= '0;
            r_opos  <= '0;
        end else begin
            if (do_drop) r_count <= r_count - CW'(1);
            else if (i_cmd.insert) r_count <= r_count + CW'(1);
            if (i_cmd.clr_pops) begin
                r_npop <= '0;
                r_opos <= '0;
            end else begin
                if (i_cmd.drop_head) r_npop <= r_npop + PW'(1);
                if (i_cmd.next_pop) r_opos <= r_opos + QW'(1);
            end
        end
    end

    logic out_last_c;
    assign out_last_c = !i_cmd.emit_pop || ((PW'(r_opos) + PW'(1)) == r_npop);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status        <= i_cmd.status;
            o_expired_valid <= i_cmd.emit_pop;
            o_expired_id    <= i_cmd.emit_pop ? 8'(r_pop_id[r_opos]) : 8'd0;
            o_next_delay    <= (r_count != '0) ? r_delta[0] : 32'd0;
            o_queue_empty   <= (r_count == '0);
            o_last          <= out_last_c;
        end
    end

    assign o_stat.req      = r_req;
    assign o_stat.ow       = r_ow;
    assign o_stat.found    = found;
    assign o_stat.full     = (r_count >= CW'(ENTRIES));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.ins_stop = !wi_live || (wi_delta >= r_rem);
    assign o_stat.adv_done = !wi_live || (r_rem == '0);
    assign o_stat.head_exp = (r_delta[0] <= {16'd0, i_min_delay_us});
    assign o_stat.pops_max = (r_npop == PW'(dltq_pkg::MAX_POPS));
    assign o_stat.pops_any = (r_npop != '0);
    assign o_stat.out_last = o_last;

endmodule

// File: src/delta_list_timer_queue_unit.sv
// Delta-list timer queue: one request item in, one or more result items out.
// A register request walks past each slot that expires before it, after first removing the
// old entry when overwrite is set; a tick walks the slots the elapsed time reaches, then pops
// head timers whose delay is at most min_delay_us, up to MAX_POPS of them. Results leave one
// after another; one request at a time, the next is taken the cycle after the last result
// leaves. Reset (synchronous, active low) empties the queue and sets min_delay_us to 0.
module delta_list_timer_queue_unit #(
    parameter int ENTRIES = dltq_pkg::ENTRIES_DEF,
    parameter int ID_BITS = dltq_pkg::ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_timer_id,
    input  logic [31:0] i_duration_us,
    input  logic        i_overwrite,
    input  logic [31:0] i_elapsed_us,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_expired_valid,
    output logic [7:0]  o_expired_id,
    output logic [31:0] o_next_delay,
    output logic        o_queue_empty,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    // The configuration register is always writable.
    logic [15:0] r_min_delay_us;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_delay_us <= '0;
        end else if (i_cfg_valid) begin
            r_min_delay_us <= i_cfg_data;
        end
    end

    dltq_pkg::t_cmd  cmd;
    dltq_pkg::t_stat stat;

    // The controller sequences search, removal, the list walks and tick pops.
    dltq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath holds the sorted list and the output register.
    dltq_datapath #(
        .ENTRIES (ENTRIES),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_req_type      (i_req_type),
        .i_timer_id      (i_timer_id),
        .i_duration_us   (i_duration_us),
        .i_overwrite     (i_overwrite),
        .i_elapsed_us    (i_elapsed_us),
        .i_min_delay_us  (r_min_delay_us),
        .o_stat          (stat),
        .o_status        (o_status),
        .o_expired_valid (o_expired_valid),
        .o_expired_id    (o_expired_id),
        .o_next_delay    (o_next_delay),
        .o_queue_empty   (o_queue_empty),
        .o_last          (o_last)
    );

endmodule
